// ----- rtl/packed_framebuffer_pixel_access_defines.svh -----
// ---------------------------------------------------------------------------
// Packed framebuffer pixel access: assertion macros
// Shared property shorthands for the port checker of the pixel access block.
// ---------------------------------------------------------------------------
`ifndef PACKED_FRAMEBUFFER_PIXEL_ACCESS_DEFINES_SVH
`define PACKED_FRAMEBUFFER_PIXEL_ACCESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfb check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfb check failed");

`endif

// ----- rtl/pfb_pkg.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer pixel access: shared definitions
// Codes, widths and types used by the front end, queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int FRAME_BYTES_DEF = 8192;
  localparam int COORD_BITS_DEF  = 10;

  // Fixed field widths.
  localparam int DIM_W      = 10;  // frame width and height registers
  localparam int BPR_W      = 10;  // bytes per row, up to 512
  localparam int IDX_W      = 20;  // byte index and frame size
  localparam int COLOR_W    = 8;
  localparam int PIX_W      = 4;
  localparam int CMD_W      = 2;
  localparam int FMT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd2;

  // Pixel format codes.
  localparam logic [FMT_W-1:0] FMT_1BPP_MSB    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_1BPP_LSB    = 3'd1;
  localparam logic [FMT_W-1:0] FMT_2BPP        = 3'd2;
  localparam logic [FMT_W-1:0] FMT_4BPP        = 3'd3;
  localparam logic [FMT_W-1:0] FMT_UNSUPPORTED = 3'd4;

  // Operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_READ,
    OP_WRITE,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic             oob;    // result flag
    logic [2:0]       shift;  // bit position of the pixel field
    logic [PIX_W-1:0] mask;   // field mask before shifting
    logic [7:0]       data;   // pixel value for a write, fill byte for a clear
  } op_ctl_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_MERGE,
    BK_CLEAR
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/pfb_front.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer front end
// Holds the configuration, accepts commands and turns each into a byte
// operation: address, field position, value and out-of-bounds decision.
// ---------------------------------------------------------------------------
`default_nettype none

module pfb_front import pfb_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int ADDR_W     = $clog2(FRAME_BYTES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Command channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [COORD_BITS-1:0] in_x_coord,
  input  wire logic [COORD_BITS-1:0] in_y_coord,
  input  wire logic [COLOR_W-1:0]    in_color,
  // Queue push side
  output logic                       push_valid,
  input  wire logic                  push_full,
  output op_ctl_t                    push_ctl,
  output logic [ADDR_W-1:0]          push_addr
);

  localparam int EXT_W = COORD_BITS + DIM_W;

  // Configuration registers.
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [FMT_W-1:0] fmt_r, fmt_nxt;

  // Classification stage registers.
  logic               st_valid_r, st_valid_nxt;
  logic [CMD_W-1:0]   st_cmd_r;
  logic [DIM_W-1:0]   st_x_r;
  logic [COLOR_W-1:0] st_color_r;
  logic [IDX_W-1:0]   st_prod_r;
  logic               st_outside_r;

  logic               accept;
  logic [BPR_W-1:0]   bpr;
  logic [DIM_W-1:0]   mult_b;
  logic [IDX_W-1:0]   prod;
  logic [EXT_W-1:0]   x_ext;
  logic [EXT_W-1:0]   y_ext;
  logic               outside;
  logic [DIM_W:0]     w_p7;
  logic [DIM_W+1:0]   w2_p7;
  logic [DIM_W:0]     w_p1;

  logic [IDX_W-1:0]   xoff;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   prod_m1;
  logic               too_big;
  logic [ADDR_W-1:0]  last_addr;
  logic               fmt_ok;
  logic [2:0]         shift;
  logic [PIX_W-1:0]   mask;
  logic [7:0]         wr_val;
  logic [7:0]         fill;

  // Configuration writes; an index past the register list is ignored.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    fmt_nxt    = fmt_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data;
        CFG_FRAME_HEIGHT: height_nxt = cfg_data;
        CFG_PIXEL_FORMAT: fmt_nxt    = cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      fmt_r    <= FMT_UNSUPPORTED;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      fmt_r    <= fmt_nxt;
    end
  end

  // Bytes per padded row in the current format.
  always_comb begin
    w_p7  = {1'b0, width_r} + (DIM_W+1)'(7);
    w2_p7 = {1'b0, width_r, 1'b0} + (DIM_W+2)'(7);
    w_p1  = {1'b0, width_r} + (DIM_W+1)'(1);
    unique case (fmt_r)
      FMT_1BPP_MSB, FMT_1BPP_LSB: bpr = BPR_W'(w_p7 >> 3);
      FMT_2BPP:                   bpr = BPR_W'(w2_p7 >> 3);
      FMT_4BPP:                   bpr = BPR_W'(w_p1 >> 1);
      default:                    bpr = '0;
    endcase
  end

  // Accept stage: one multiply, row offset for pixels or frame size for a clear.
  assign in_stall   = st_valid_r && push_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = st_valid_r;

  assign x_ext   = EXT_W'(in_x_coord);
  assign y_ext   = EXT_W'(in_y_coord);
  assign outside = (x_ext >= EXT_W'(width_r)) || (y_ext >= EXT_W'(height_r));
  assign mult_b  = (in_command == CMD_CLEAR) ? height_r : y_ext[DIM_W-1:0];
  assign prod    = IDX_W'(bpr) * IDX_W'(mult_b);

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (accept) begin
      st_valid_nxt = 1'b1;
    end else if (!push_full) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd_r     <= in_command;
      st_x_r       <= x_ext[DIM_W-1:0];
      st_color_r   <= in_color;
      st_prod_r    <= prod;
      st_outside_r <= outside;
    end
  end

  // Field position, mask, write value and fill byte per format.
  always_comb begin
    fmt_ok = 1'b1;
    unique case (fmt_r)
      FMT_1BPP_MSB: begin
        xoff   = IDX_W'(st_x_r >> 3);
        shift  = 3'd7 - st_x_r[2:0];
        mask   = 4'h1;
        wr_val = {7'b0, (st_color_r != '0)};
        fill   = (st_color_r != '0) ? 8'hFF : 8'h00;
      end
      FMT_1BPP_LSB: begin
        xoff   = IDX_W'(st_x_r >> 3);
        shift  = st_x_r[2:0];
        mask   = 4'h1;
        wr_val = {7'b0, (st_color_r != '0)};
        fill   = (st_color_r != '0) ? 8'hFF : 8'h00;
      end
      FMT_2BPP: begin
        xoff   = IDX_W'(st_x_r >> 2);
        shift  = {~st_x_r[1:0], 1'b0};
        mask   = 4'h3;
        wr_val = {6'b0, st_color_r[1:0]};
        fill   = {4{st_color_r[1:0]}};
      end
      FMT_4BPP: begin
        xoff   = IDX_W'(st_x_r >> 1);
        shift  = st_x_r[0] ? 3'd0 : 3'd4;
        mask   = 4'hF;
        wr_val = {4'b0, st_color_r[3:0]};
        fill   = {2{st_color_r[3:0]}};
      end
      default: begin
        fmt_ok = 1'b0;
        xoff   = '0;
        shift  = '0;
        mask   = '0;
        wr_val = '0;
        fill   = '0;
      end
    endcase
  end

  assign idx     = st_prod_r + xoff;
  assign prod_m1 = st_prod_r - IDX_W'(1);
  assign too_big = st_prod_r > IDX_W'(FRAME_BYTES);
  assign last_addr = too_big ? ADDR_W'(FRAME_BYTES - 1) : prod_m1[ADDR_W-1:0];

  // Classification into the operation the back end carries out.
  always_comb begin
    push_ctl.kind  = OP_NOP;
    push_ctl.oob   = 1'b1;
    push_ctl.shift = shift;
    push_ctl.mask  = mask;
    push_ctl.data  = wr_val;
    push_addr      = idx[ADDR_W-1:0];
    priority if (!fmt_ok) begin
      push_ctl.kind = OP_NOP;
    end else if (st_cmd_r == CMD_CLEAR) begin
      push_ctl.data = fill;
      push_addr     = last_addr;
      if (st_prod_r != '0) begin
        push_ctl.kind = OP_CLEAR;
        push_ctl.oob  = too_big;
      end
    end else if (st_cmd_r != CMD_WRITE && st_cmd_r != CMD_READ) begin
      push_ctl.kind = OP_NOP;
    end else if (st_outside_r || idx >= IDX_W'(FRAME_BYTES)) begin
      push_ctl.kind = OP_NOP;
    end else begin
      push_ctl.kind = (st_cmd_r == CMD_READ) ? OP_READ : OP_WRITE;
      push_ctl.oob  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfb_queue.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer operation queue
// A short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module pfb_queue import pfb_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfb_back.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer back end
// Owns the frame memory and carries out reads, read-modify-writes and
// clear walks, then presents one result per operation.
// ---------------------------------------------------------------------------
`default_nettype none

module pfb_back import pfb_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int ADDR_W     = $clog2(FRAME_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Queue pop side
  input  wire logic              q_empty,
  input  wire op_ctl_t           q_ctl,
  input  wire logic [ADDR_W-1:0] q_addr,
  output logic                   q_pop,
  // Result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PIX_W-1:0]       out_pixel_value,
  output logic                   out_out_of_bounds
);

  // Frame memory: one write and one registered read per cycle.
  logic [7:0]        mem [FRAME_BYTES];
  logic [7:0]        rdata_r;
  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  back_state_t       state_r, state_nxt;
  op_ctl_t           op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_oob_r;

  logic              out_free;
  logic              res_load;
  logic [PIX_W-1:0]  res_pix;
  logic              res_oob;
  logic [7:0]        field;
  logic [PIX_W-1:0]  pix_sel;
  logic [7:0]        mask8;
  logic [7:0]        merged;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[q_addr];
    end
  end

  // Field extraction for reads and merge for writes.
  assign field   = rdata_r >> op_r.shift;
  assign pix_sel = field[PIX_W-1:0] & op_r.mask;
  assign mask8   = {4'b0, op_r.mask} << op_r.shift;
  assign merged  = (rdata_r & ~mask8) | (op_r.data << op_r.shift);

  // The result slot is free now or empties at this edge.
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: an operation is taken only when its result has somewhere to go.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    ptr_nxt   = ptr_r;
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = merged;
    res_load  = 1'b0;
    res_pix   = '0;
    res_oob   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop    = 1'b1;
          op_nxt   = q_ctl;
          addr_nxt = q_addr;
          ptr_nxt  = '0;
          unique case (q_ctl.kind)
            OP_NOP: begin
              res_load = 1'b1;
              res_oob  = q_ctl.oob;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              state_nxt = BK_READ;
            end
            OP_WRITE: begin
              mem_re    = 1'b1;
              state_nxt = BK_MERGE;
            end
            OP_CLEAR: begin
              state_nxt = BK_CLEAR;
            end
          endcase
        end
      end
      BK_READ: begin
        res_load  = 1'b1;
        res_pix   = pix_sel;
        state_nxt = BK_IDLE;
      end
      BK_MERGE: begin
        mem_we    = 1'b1;
        res_load  = 1'b1;
        state_nxt = BK_IDLE;
      end
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = op_r.data;
        if (ptr_r == addr_r) begin
          res_load  = 1'b1;
          res_oob   = op_r.oob;
          state_nxt = BK_IDLE;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    ptr_r  <= ptr_nxt;
  end

  // Output register: holds a result until the transaction completes.
  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pix_r <= res_pix;
      out_oob_r <= res_oob;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_value   = out_pix_r;
  assign out_out_of_bounds = out_oob_r;

endmodule

`default_nettype wire

// ----- rtl/packed_framebuffer_pixel_access.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer pixel access
// Pixel write, pixel read and whole-frame clear on a byte-wide frame memory
// holding 1, 2 or 4 bit packed pixels.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Contents
//   in_*      input      in_valid / in_stall  command, x, y, colour
//   out_*     output     out_valid/out_stall  pixel value, out-of-bounds flag
//   cfg_*     input      cfg_wr_en            width, height, pixel format
//
// A command is registered in the front-end stage before it reaches the queue.
// The back end answers an ignored command as it pops it; for a pixel read
// or write it reads the byte, then returns the field or writes the merged
// byte, and for a clear it writes each filled byte in turn. It pops no new
// command until it is done with the last one.
// Reset is synchronous and clears control state only; the frame memory is
// undefined until written, so no clearing pass runs after reset.
// The queue lets commands be taken while the back end is busy or a result
// is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module packed_framebuffer_pixel_access import pfb_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Commands
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [COORD_BITS-1:0] in_x_coord,
  input  wire logic [COORD_BITS-1:0] in_y_coord,
  input  wire logic [COLOR_W-1:0]    in_color,
  // Results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_pixel_value,
  output logic                       out_out_of_bounds
);

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int Q_W    = $bits(op_ctl_t) + ADDR_W;

  logic              push_valid;
  logic              push_full;
  op_ctl_t           push_ctl;
  logic [ADDR_W-1:0] push_addr;
  logic [Q_W-1:0]    push_data;
  logic [Q_W-1:0]    pop_data;
  logic              q_pop;
  logic              q_empty;
  op_ctl_t           q_ctl;
  logic [ADDR_W-1:0] q_addr;

  // Front end: configuration, acceptance and classification.
  pfb_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .in_color   (in_color),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_ctl   (push_ctl),
    .push_addr  (push_addr)
  );

  // Operation queue between the two halves.
  assign push_data = {push_ctl, push_addr};
  assign q_ctl     = pop_data[Q_W-1:ADDR_W];
  assign q_addr    = pop_data[ADDR_W-1:0];

  pfb_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (push_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Back end: frame memory and result register.
  pfb_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_ctl             (q_ctl),
    .q_addr            (q_addr),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_out_of_bounds (out_out_of_bounds)
  );

endmodule

`default_nettype wire

// ----- rtl/pfb_checker.sv -----
// ---------------------------------------------------------------------------
// Packed framebuffer port checker
// Watches the command and result channels of the pixel access block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "packed_framebuffer_pixel_access_defines.svh"

module pfb_checker import pfb_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] out_pixel_value,
  input wire logic             out_out_of_bounds
);

  // At most five transactions are in flight: front stage, queue, back end,
  // result register.
  localparam int MAX_OPEN = 5;

  logic [2:0] open_r, open_nxt;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Count of accepted commands whose result has not yet been delivered.
  always_comb begin
    open_nxt = open_r;
    if (in_take && !out_take) begin
      open_nxt = open_r + 3'd1;
    end else if (out_take && !in_take) begin
      open_nxt = open_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  // A stalled result holds its value.
  `PFB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel_value) && $stable(out_out_of_bounds))
  // An ignored command never returns pixel bits.
  `PFB_ASSERT_NOW(a_oob_zero, clk, rst_n, out_valid && out_out_of_bounds, out_pixel_value == '0)
  // No result without an accepted command behind it.
  `PFB_ASSERT_NOW(a_no_spurious, clk, rst_n, out_valid, open_r != '0)
  // Commands are refused only when the pipeline is genuinely full.
  `PFB_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, open_r >= 3'd3)
  // The in-flight count stays within the storage of the design.
  `PFB_ASSERT_NOW(a_open_bound, clk, rst_n, 1'b1, open_r <= 3'(MAX_OPEN))

endmodule

bind packed_framebuffer_pixel_access pfb_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_packed_framebuffer_pixel_access.sv -----
// ----------------------------------------------------------------------------
// Testbench for the packed framebuffer pixel access block
// Sends pixel write, pixel read and frame clear transactions under several
// frame settings and checks every result against a behavioural predictor
// that keeps its own copy of the frame memory. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_packed_framebuffer_pixel_access import pfb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES = FRAME_BYTES_DEF;
  localparam int RANDOM_ITEMS = 440;
  localparam int MAX_PRINTED = 40;
  // The two-bit command field has one spare code, which the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             out_of_bounds;
  } pixel_result_t;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = '0;
  logic [COORD_BITS_DEF-1:0] in_x_coord = '0;
  logic [COORD_BITS_DEF-1:0] in_y_coord = '0;
  logic [COLOR_W-1:0] in_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] out_pixel_value;
  logic out_out_of_bounds;

  // Predicted frame contents, with a mask of the bits that have been set.
  bit [7:0] frame_img [MEM_BYTES];
  bit [7:0] byte_known [MEM_BYTES];
  int cur_width;
  int cur_height;
  logic [FMT_W-1:0] cur_format;

  pixel_result_t expected_pixels [$];

  // Traffic shaping and statistics.
  bit stall_on = 1'b0;
  bit send_gaps = 1'b0;
  int hold_cycles = 0;
  int stall_run = 0;
  int flow_run = 0;
  int err_count = 0;
  int checked_count = 0;
  int sent_total = 0;
  int write_count = 0;
  int read_count = 0;
  int clear_count = 0;
  int ignored_count = 0;
  int config_count = 0;

  packed_framebuffer_pixel_access u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_out_of_bounds(out_out_of_bounds)
  );

  always #1 clk = ~clk;

  // Idle lengths from three ranges: the shortest most often, now and then a long stretch.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Bytes in one padded row for the current format.
  function automatic int padded_row_bytes();
    case (cur_format)
      FMT_1BPP_MSB, FMT_1BPP_LSB: return (cur_width + 7) >> 3;
      FMT_2BPP: return (cur_width * 2 + 7) >> 3;
      FMT_4BPP: return (cur_width + 1) >> 1;
      default: return 0;
    endcase
  endfunction

  // Byte index, bit position and field mask of a pixel.
  function automatic void locate_pixel(input int x, input int y, output int idx,
                                       output int shift, output int mask);
    int rb;
    rb = padded_row_bytes();
    case (cur_format)
      FMT_1BPP_MSB: begin
        idx = y * rb + (x >> 3);
        shift = 7 - (x & 7);
        mask = 1;
      end
      FMT_1BPP_LSB: begin
        idx = y * rb + (x >> 3);
        shift = x & 7;
        mask = 1;
      end
      FMT_2BPP: begin
        idx = y * rb + (x >> 2);
        shift = 6 - (x & 3) * 2;
        mask = 3;
      end
      default: begin
        idx = y * rb + (x >> 1);
        shift = (x & 1) ? 0 : 4;
        mask = 15;
      end
    endcase
  endfunction

  // True when a read of this pixel touches no byte bit that is still unset.
  function automatic bit pixel_defined(input int x, input int y);
    int idx, shift, mask;
    if (cur_format > FMT_4BPP || x >= cur_width || y >= cur_height) return 1'b1;
    locate_pixel(x, y, idx, shift, mask);
    if (idx >= MEM_BYTES) return 1'b1;
    return ((int'(byte_known[idx]) >> shift) & mask) == mask;
  endfunction

  // Applies one command to the predicted frame and returns its result.
  function automatic pixel_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input int x, input int y,
                                                  input int color);
    pixel_result_t res;
    int size, n, fill, idx, shift, mask, v, i;
    res.pixel_value = '0;
    res.out_of_bounds = 1'b0;
    if (cur_format > FMT_4BPP || cmd == CMD_UNKNOWN) begin
      res.out_of_bounds = 1'b1;
    end else if (cmd == CMD_CLEAR) begin
      size = padded_row_bytes() * cur_height;
      if (cur_format == FMT_1BPP_MSB || cur_format == FMT_1BPP_LSB)
        fill = (color != 0) ? 'hFF : 0;
      else if (cur_format == FMT_2BPP)
        fill = (color & 3) * 'h55;
      else
        fill = (color & 15) * 'h11;
      if (size == 0) begin
        res.out_of_bounds = 1'b1;
      end else begin
        n = size;
        if (n > MEM_BYTES) begin
          n = MEM_BYTES;
          res.out_of_bounds = 1'b1;
        end
        for (i = 0; i < n; i++) begin
          frame_img[i] = 8'(fill);
          byte_known[i] = 8'hFF;
        end
      end
    end else if (x >= cur_width || y >= cur_height) begin
      res.out_of_bounds = 1'b1;
    end else begin
      locate_pixel(x, y, idx, shift, mask);
      if (idx >= MEM_BYTES) begin
        res.out_of_bounds = 1'b1;
      end else if (cmd == CMD_READ) begin
        res.pixel_value = PIX_W'((int'(frame_img[idx]) >> shift) & mask);
      end else begin
        v = (mask == 1) ? int'(color != 0) : (color & mask);
        frame_img[idx] = 8'((int'(frame_img[idx]) & ~(mask << shift)) | (v << shift));
        byte_known[idx] = 8'(int'(byte_known[idx]) | (mask << shift));
      end
    end
    return res;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTED)
      $display("%0t: mismatch in %s on result %0d: got %0d, expected %0d",
               $realtime, what, checked_count, got, want);
    err_count++;
  endtask

  // Sender side idle; the argument sets how long.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one transaction, waits for it to be taken and predicts its result.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input int x, input int y,
                              input int color);
    pixel_result_t res;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_x_coord <= COORD_BITS_DEF'(x);
    in_y_coord <= COORD_BITS_DEF'(y);
    in_color <= COLOR_W'(color);
    do @(posedge clk); while (in_stall !== 1'b0);
    res = apply_command(cmd, x & 'h3FF, y & 'h3FF, color & 'hFF);
    expected_pixels.push_back(res);
    sent_total++;
    if (res.out_of_bounds) ignored_count++;
    else if (cmd == CMD_WRITE) write_count++;
    else if (cmd == CMD_READ) read_count++;
    else clear_count++;
    if (send_gaps && $urandom_range(0, 3) == 0) idle_cycles(gap_len());
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Writes all three frame registers once the block is idle.
  task automatic configure(input int w, input int h, input int fmt);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_PIXEL_FORMAT;
    cfg_data <= CFG_DATA_W'(fmt);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_width = w & 'h3FF;
    cur_height = h & 'h3FF;
    cur_format = fmt[FMT_W-1:0];
    config_count++;
  endtask

  // One random transaction, mostly inside the frame and inside memory.
  task automatic random_command();
    int r, x, y, color, rb, ymax;
    logic [CMD_W-1:0] cmd;
    color = $urandom_range(0, 255);
    x = $urandom_range(0, 1023);
    y = $urandom_range(0, 1023);
    if ($urandom_range(0, 99) < 85 && cur_width > 0 && cur_height > 0) begin
      rb = padded_row_bytes();
      ymax = cur_height;
      if (rb > 0 && MEM_BYTES / rb < ymax && $urandom_range(0, 9) != 0)
        ymax = MEM_BYTES / rb;
      x = $urandom_range(0, cur_width - 1);
      y = $urandom_range(0, ymax - 1);
    end
    r = $urandom_range(0, 99);
    if (r < 48) cmd = CMD_WRITE;
    else if (r < 95) cmd = CMD_READ;
    else if (r < 98) cmd = CMD_CLEAR;
    else cmd = CMD_UNKNOWN;
    // A read of bits that nothing has set yet is turned into a write.
    if (cmd == CMD_READ && !pixel_defined(x, y)) cmd = CMD_WRITE;
    send_command(cmd, x, y, color);
  endtask

  // Frame dimension: mostly small, sometimes zero, full size or anywhere.
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    if (r == 2) return $urandom_range(0, 1023);
    return $urandom_range(1, 24);
  endfunction

  // Receiver stall: a long hold-off when asked, otherwise random runs.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (flow_run > 0) begin
      out_stall <= 1'b0;
      flow_run--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_run = gap_len();
      flow_run = $urandom_range(1, 16);
    end
  end

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", int'(out_pixel_value), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", int'(out_pixel_value), int'(want.pixel_value));
        if (out_out_of_bounds !== want.out_of_bounds)
          report_mismatch("out_of_bounds", int'(out_out_of_bounds),
                          int'(want.out_of_bounds));
      end
      checked_count++;
    end
  end

  // After reset the format is unsupported and the frame is empty.
  task automatic test_unsupported_format();
    send_command(CMD_WRITE, 0, 0, 'hFF);
    send_command(CMD_CLEAR, 0, 0, 'h00);
    send_command(CMD_UNKNOWN, 5, 5, 'h01);
  endtask

  // Zero width: a clear writes nothing and every pixel access is ignored.
  task automatic test_empty_frame();
    configure(0, 5, int'(FMT_1BPP_MSB));
    send_command(CMD_CLEAR, 0, 0, 'h01);
    send_command(CMD_WRITE, 0, 0, 'h01);
  endtask

  // 1 bpp MSB first with a padded row, plus both edges of the frame.
  task automatic test_1bpp_msb();
    configure(20, 3, int'(FMT_1BPP_MSB));
    send_command(CMD_CLEAR, 0, 0, 'hFF);
    send_command(CMD_WRITE, 19, 2, 'h00);
    send_command(CMD_READ, 19, 2, 'h00);
    send_command(CMD_READ, 18, 2, 'h00);
    send_command(CMD_READ, 20, 0, 'h00);
    send_command(CMD_READ, 0, 3, 'h00);
  endtask

  // Full-size 4 bpp frame: the clear overruns memory, so do far pixels.
  task automatic test_4bpp_large_frame();
    configure(1023, 1023, int'(FMT_4BPP));
    send_command(CMD_CLEAR, 0, 0, 'hA5);
    send_command(CMD_WRITE, 1022, 15, 'hFF);
    send_command(CMD_READ, 1022, 15, 'h00);
    send_command(CMD_READ, 0, 16, 'h00);
    send_command(CMD_WRITE, 1023, 1023, 'h0F);
    send_command(CMD_UNKNOWN, 1, 1, 'h0F);
  endtask

  // 2 bpp keeps only the low two colour bits.
  task automatic test_2bpp();
    configure(7, 2, int'(FMT_2BPP));
    send_command(CMD_CLEAR, 0, 0, 'h02);
    send_command(CMD_WRITE, 6, 1, 'hFD);
    send_command(CMD_READ, 6, 1, 'h00);
    send_command(CMD_READ, 5, 1, 'h00);
  endtask

  // 1 bpp LSB first: any nonzero colour sets the bit.
  task automatic test_1bpp_lsb();
    configure(9, 1, int'(FMT_1BPP_LSB));
    send_command(CMD_CLEAR, 0, 0, 'h00);
    send_command(CMD_WRITE, 8, 0, 'h80);
    send_command(CMD_READ, 8, 0, 'h00);
    send_command(CMD_READ, 0, 0, 'h00);
  endtask

  // The receiver holds off while transactions keep coming, then the
  // sender pauses until everything has drained.
  task automatic test_backpressure();
    configure(16, 4, int'(FMT_4BPP));
    stall_on = 1'b0;
    send_gaps = 1'b0;
    send_command(CMD_CLEAR, 0, 0, 'h3C);
    hold_cycles = 80;
    repeat (24) random_command();
    wait_drained();
    idle_cycles(gap_len());
  endtask

  // Random frame settings, each followed by a burst of random transactions.
  task automatic test_random_traffic();
    int target, fmt, quiet;
    target = sent_total + RANDOM_ITEMS;
    while (sent_total < target) begin
      fmt = ($urandom_range(0, 9) == 0) ? int'(FMT_UNSUPPORTED)
                                        : int'($urandom_range(0, 3));
      configure(pick_dim(), pick_dim(), fmt);
      quiet = int'($urandom_range(0, 3) == 0);
      stall_on = (quiet == 0);
      send_gaps = (quiet == 0);
      if (fmt <= int'(FMT_4BPP) && $urandom_range(0, 4) != 0)
        send_command(CMD_CLEAR, 0, 0, $urandom_range(0, 255));
      repeat ($urandom_range(15, 40)) random_command();
    end
  endtask

  // Test sequence.
  initial begin
    cur_width = 0;
    cur_height = 0;
    cur_format = FMT_UNSUPPORTED;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_on = 1'b1;
    send_gaps = 1'b1;
    test_unsupported_format();
    test_empty_frame();
    test_1bpp_msb();
    test_4bpp_large_frame();
    test_2bpp();
    test_1bpp_lsb();
    test_backpressure();
    test_random_traffic();
    stall_on = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d transactions: %0d writes, %0d reads, %0d clears, %0d ignored.",
             sent_total, write_count, read_count, clear_count, ignored_count);
    $display("Checked %0d results over %0d frame settings.", checked_count, config_count);
    if (err_count == 0) begin
      $display("[packed_framebuffer_pixel_access] OK");
    end else begin
      $display("[packed_framebuffer_pixel_access] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("[packed_framebuffer_pixel_access] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
